/* sv/rcu_pkg.sv */
package rcu_pkg;

  localparam int ValueW = 32;
  localparam int RankW  = 6;
  localparam int CountW = RankW + 1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              overflow;
  } job_t;

  typedef enum logic [4:0] {
    BackIdle  = 5'b00001,
    BackKey   = 5'b00010,
    BackLoad  = 5'b00100,
    BackSweep = 5'b01000,
    BackEmit  = 5'b10000
  } back_state_e;

endpackage

/* sv/rcu_ram.sv */
module rcu_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rcu_front.sv */
module rcu_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rcu_pkg::ValueW-1:0]    sample_value_i,
  input  logic                                 is_last_i,
  input  logic                                 done_i,
  output logic                                 busy_o,
  output logic                                 we_o,
  output logic [$clog2(MAX_ITEMS):0]           waddr_o,
  output logic [rcu_pkg::ValueW-1:0]           wdata_o,
  output logic                                 push_o,
  output rcu_pkg::job_t                        job_o
);
  import rcu_pkg::*;

  localparam int IdxW = $clog2(MAX_ITEMS);
  localparam int CntW = $clog2(MAX_ITEMS + 1);

  logic [CntW-1:0] count_q, count_d, count_next;
  logic            ovf_q, ovf_d;
  logic            bank_q, bank_d;
  logic [1:0]      pend_q, pend_d;
  logic            accept, room;

  assign busy_o     = (pend_q == 2'd2);
  assign accept     = start_i && !busy_o;
  assign room       = (count_q < CntW'(MAX_ITEMS));
  assign count_next = room ? count_q + CntW'(1) : count_q;

  assign we_o    = accept && room;
  assign waddr_o = {bank_q, count_q[IdxW-1:0]};
  assign wdata_o = sample_value_i;

  assign push_o         = accept && is_last_i;
  assign job_o.count    = CountW'(count_next);
  assign job_o.overflow = ovf_q || !room;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    bank_d  = bank_q;
    if (accept) begin
      if (is_last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
        bank_d  = !bank_q;
      end else begin
        count_d = count_next;
        ovf_d   = ovf_q || !room;
      end
    end
    pend_d = pend_q + 2'(push_o) - 2'(done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      pend_q  <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* sv/rcu_job_fifo.sv */
module rcu_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcu_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          empty_o,
  output rcu_pkg::job_t job_o
);
  import rcu_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] level_q;

  assign empty_o = (level_q == 2'd0);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      level_q <= level_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* sv/rcu_back.sv */
module rcu_back #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  rcu_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [$clog2(MAX_ITEMS):0]    raddr_o,
  input  logic [rcu_pkg::ValueW-1:0]    rdata_i,
  output logic                          result_valid_o,
  output logic [rcu_pkg::RankW-1:0]     rank_o,
  output logic                          last_rank_o,
  output logic                          overflow_o
);
  import rcu_pkg::*;

  localparam int IdxW = $clog2(MAX_ITEMS);

  back_state_e              state_q, state_d;
  logic                     bank_q, bank_d;
  logic [CountW-1:0]        n_q, n_d;
  logic                     ovf_q, ovf_d;
  logic [CountW-1:0]        k_q, k_d;
  logic [CountW-1:0]        j_q, j_d;
  logic [CountW-1:0]        cnt_q, cnt_d;
  logic signed [ValueW-1:0] key_q, key_d;
  logic                     lt, is_last;

  assign lt      = $signed(rdata_i) < key_q;
  assign is_last = (k_q + CountW'(1) == n_q);

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    k_d     = k_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    pop_o   = 1'b0;
    done_o  = 1'b0;
    raddr_o = {bank_q, k_q[IdxW-1:0]};
    case (state_q)
      BackIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          n_d     = job_i.count;
          ovf_d   = job_i.overflow;
          k_d     = '0;
          state_d = BackKey;
        end
      end
      BackKey: begin
        state_d = BackLoad;
      end
      BackLoad: begin
        key_d   = $signed(rdata_i);
        raddr_o = {bank_q, IdxW'(0)};
        j_d     = CountW'(1);
        cnt_d   = '0;
        state_d = BackSweep;
      end
      BackSweep: begin
        raddr_o = {bank_q, j_q[IdxW-1:0]};
        cnt_d   = cnt_q + CountW'(lt);
        if (j_q == n_q) begin
          state_d = BackEmit;
        end else begin
          j_d = j_q + CountW'(1);
        end
      end
      BackEmit: begin
        k_d = k_q + CountW'(1);
        if (is_last) begin
          done_o  = 1'b1;
          bank_d  = !bank_q;
          state_d = BackIdle;
        end else begin
          state_d = BackKey;
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    ovf_q <= ovf_d;
    k_q   <= k_d;
    j_q   <= j_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
  end

  assign result_valid_o = (state_q == BackEmit);
  assign rank_o         = cnt_q[RankW-1:0];
  assign last_rank_o    = is_last;
  assign overflow_o     = ovf_q;

endmodule

/* sv/rank_compaction_unit.sv */
// Rank compaction: load a sequence of signed values, one beat per cycle while
// busy_o is low, the final one marked by is_last_i. Afterwards the ranks (count
// of strictly smaller values) come out in load order, one beat per strobe on
// result_valid_o; the receiver cannot stall, so every strobe must be taken.
// Values beyond MAX_ITEMS are dropped and flagged on overflow_o. Each rank
// comes from one read port sweeping the stored values once per rank: a key
// read, a key load, a compare per stored value, then the result strobe. The
// store has two banks, so a new sequence loads while the previous one is
// ranked; busy_o is high while both banks hold sequences waiting for or
// under ranking.
module rank_compaction_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [rcu_pkg::ValueW-1:0] sample_value_i,
  input  logic                              is_last_i,
  output logic                              result_valid_o,
  output logic [rcu_pkg::RankW-1:0]         rank_o,
  output logic                              last_rank_o,
  output logic                              overflow_o
);
  import rcu_pkg::*;

  localparam int AddrW    = $clog2(MAX_ITEMS) + 1;
  localparam int RamDepth = 2 ** AddrW;

  logic              we, push, pop, empty, done;
  logic [AddrW-1:0]  waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;
  job_t              job_in, job_out;

  rcu_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .sample_value_i,
    .is_last_i,
    .done_i  (done),
    .busy_o,
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .push_o  (push),
    .job_o   (job_in)
  );

  rcu_ram #(.Width(ValueW), .Depth(RamDepth)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rcu_job_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  rcu_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .done_o  (done),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .result_valid_o,
    .rank_o,
    .last_rank_o,
    .overflow_o
  );

endmodule

/* sv/rcu_checker.sv */
module rcu_checker #(
  parameter int MAX_ITEMS = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic signed [rcu_pkg::ValueW-1:0] sample_value_i,
  input logic                              is_last_i,
  input logic                              result_valid_o,
  input logic [rcu_pkg::RankW-1:0]         rank_o,
  input logic                              last_rank_o,
  input logic                              overflow_o
);

  // a rank is followed by at least a key read, a load and one compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o ##1 !result_valid_o ##1 !result_valid_o)
    else $error("result beats too close together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rank_o < MAX_ITEMS))
    else $error("rank beyond capacity");

  // both banks fill only on the marked beat of a sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && is_last_i))
    else $error("busy without a finished sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_rank_o |=> ##3 (!result_valid_o || !$isunknown(overflow_o)))
    else $error("overflow flag unknown within a sequence");

endmodule

bind rank_compaction_unit rcu_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (.*);

/* tb/tb_rank_compaction_unit.sv */
module tb_rank_compaction_unit;
  import rcu_pkg::*;

  localparam int MaxItems = 64;
  localparam int SettleCycles = MaxItems + 8;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             last_rank;
    logic             overflow;
  } rank_beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic signed [ValueW-1:0] sample_value_i = '0;
  logic                     is_last_i = 1'b0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic [RankW-1:0]         rank_o;
  logic                     last_rank_o;
  logic                     overflow_o;

  logic signed [ValueW-1:0] seq_values[$];
  logic                     seq_dropped = 1'b0;
  rank_beat_t               rank_expect_q[$];
  rank_beat_t               rank_want;
  int unsigned              error_count = 0;
  int unsigned              sender_idle_pct = 0;

  rank_compaction_unit #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .sample_value_i(sample_value_i),
    .is_last_i     (is_last_i),
    .result_valid_o(result_valid_o),
    .rank_o        (rank_o),
    .last_rank_o   (last_rank_o),
    .overflow_o    (overflow_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // rank = number of stored values strictly smaller, in load order
  function automatic void predict_ranks();
    rank_beat_t  beat;
    int unsigned smaller;
    for (int i = 0; i < seq_values.size(); i++) begin
      smaller = 0;
      for (int j = 0; j < seq_values.size(); j++) begin
        if (seq_values[j] < seq_values[i]) smaller++;
      end
      beat.rank      = smaller[RankW-1:0];
      beat.last_rank = (i == seq_values.size() - 1);
      beat.overflow  = seq_dropped;
      rank_expect_q.push_back(beat);
    end
    seq_values.delete();
    seq_dropped = 1'b0;
  endfunction

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(2))
      0: return $urandom;
      1: return ValueW'($urandom_range(8)) - ValueW'(4);
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input logic signed [ValueW-1:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i        <= 1'b0;
      sample_value_i <= $urandom;
      is_last_i      <= 1'($urandom_range(1));
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    sample_value_i <= value;
    is_last_i      <= last;
    do @(posedge clk_i); while (busy_o);
    if (seq_values.size() < MaxItems) seq_values.push_back(value);
    else seq_dropped = 1'b1;
    if (last) predict_ranks();
  endtask

  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) send_beat(rand_value(), i == len - 1);
  endtask

  task automatic drain_ranks();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (rank_expect_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_single_value();
    sender_idle_pct = 0;
    send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_extremes();
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(32'shffff_ffff, 1'b0);
    send_beat(32'sh0000_0001, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh0000_0000, 1'b1);
  endtask

  task automatic test_ties_and_order();
    for (int i = 0; i < 5; i++) send_beat(32'sd5, i == 4);
    for (int i = 3; i >= 0; i--) send_beat(ValueW'(i) - ValueW'(1), i == 0);
  endtask

  task automatic test_store_full();
    sender_idle_pct = 0;
    send_sequence(MaxItems);
  endtask

  // marked beat lands past capacity and is dropped
  task automatic test_overflow();
    sender_idle_pct = 14;
    send_sequence(MaxItems + 2);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int n_beats);
    int sent;
    int len;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_beats) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_sequence(len);
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (rank_expect_q.size() == 0) begin
        $error("unexpected rank beat: rank %0d last_rank %0b overflow %0b",
               rank_o, last_rank_o, overflow_o);
        error_count++;
      end else begin
        rank_want = rank_expect_q.pop_front();
        if (rank_o !== rank_want.rank) begin
          $error("rank: expected %0d, got %0d", rank_want.rank, rank_o);
          error_count++;
        end
        if (last_rank_o !== rank_want.last_rank) begin
          $error("last_rank: expected %0b, got %0b", rank_want.last_rank, last_rank_o);
          error_count++;
        end
        if (overflow_o !== rank_want.overflow) begin
          $error("overflow: expected %0b, got %0b", rank_want.overflow, overflow_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_single_value();
    test_extremes();
    test_ties_and_order();
    drain_ranks();
    test_store_full();
    test_overflow();
    drain_ranks();
    test_random(0, 8);
    test_random(85, 8);
    test_random(14, 8);
    drain_ranks();
    if (rank_expect_q.size() != 0) begin
      $error("%0d rank beats never arrived", rank_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
